// ===== rtl/core/ec_pkg.sv =====
// shared types, constants and month table for the epoch to calendar converter
`timescale 1ns / 1ps

package ec_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned DVS_W    = 6;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned YEAR_W   = 12;

  localparam logic [DVS_W-1:0]  DIV_SIXTY   = 6'd60;
  localparam logic [DVS_W-1:0]  DIV_DAY     = 6'd24;
  localparam logic [DVS_W-1:0]  DIV_WEEK    = 6'd7;
  localparam logic [CNT_W-1:0]  BITS_SECS   = 6'd32;
  localparam logic [CNT_W-1:0]  BITS_MINS   = 6'd27;
  localparam logic [CNT_W-1:0]  BITS_HOURS  = 6'd21;
  localparam logic [CNT_W-1:0]  BITS_DAYS   = 6'd16;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 12'd1970;
  localparam logic [DAYS_W-1:0] EPOCH_WDAY  = 16'd4;
  localparam logic [8:0]        LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [8:0]        COMMON_YEAR_DAYS = 9'd365;
  localparam logic [3:0]        LAST_MONTH  = 4'd11;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [CNT_W-1:0]  nbits;
    logic [DVS_W-1:0]  divisor;
  } ec_div_cmd_t;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/ec_sdiv.sv =====
// bit-serial restoring divider by a small constant, one quotient bit per cycle
`timescale 1ns / 1ps

module ec_sdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ec_pkg::ec_div_cmd_t         cmd,
  output logic                        done,
  output logic [ec_pkg::WORD_W-1:0]   quotient,
  output logic [ec_pkg::DVS_W-1:0]    remainder
);
  import ec_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   q_r, q_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    div_r, div_nxt;
  logic [DVS_W:0]      trial;
  logic [DVS_W:0]      diff;
  logic                ge;

  assign trial = {rem_r, q_r[WORD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (cmd.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.nbits;
      q_nxt    = cmd.dividend;
      rem_nxt  = '0;
      div_nxt  = cmd.divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[WORD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still shifting");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0)
    else $error("divider running with empty bit count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < div_r)
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/epoch_to_calendar.sv =====
// top level: unix seconds to calendar fields with serial dividers and year/month stepping
//
//  channel  | ports                         | transfer
//  ---------+-------------------------------+--------------------------------
//  input    | start, busy, in_epoch_seconds | start high and busy low at edge
//  result   | out_valid, out_*              | one-cycle strobe, no back-pressure
//
//  the result strobe follows the bit-serial divisions by 60, 60 and 24 over
//  32, 27 and 21 quotient bits, then year stepping (up to 136 years) and month
//  stepping (up to 11 months), one year or month at a time; the 16-bit weekday
//  division by 7 runs alongside and the result strobe waits for its remainder.
//  reset is synchronous and active low; results cannot be stalled and a new
//  transaction may start at the edge that ends the result strobe.
`timescale 1ns / 1ps

module epoch_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [2:0]  out_weekday,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [11:0] out_full_year
);
  import ec_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEC  = 3'd1;
  localparam logic [2:0] ST_MIN  = 3'd2;
  localparam logic [2:0] ST_HOUR = 3'd3;
  localparam logic [2:0] ST_YEAR = 3'd4;
  localparam logic [2:0] ST_MON  = 3'd5;
  localparam logic [2:0] ST_WAIT = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [DAYS_W-1:0] days_r, days_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [2:0]        wday_r, wday_nxt;
  logic              wday_ok_r, wday_ok_nxt;
  logic              out_valid_r, out_valid_nxt;

  ec_div_cmd_t       a_cmd, b_cmd;
  logic              a_done, b_done;
  logic [WORD_W-1:0] a_quot, b_quot;
  logic [DVS_W-1:0]  a_rem, b_rem;

  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [DAYS_W-1:0] days_in;

  ec_sdiv u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (a_cmd),
    .done      (a_done),
    .quotient  (a_quot),
    .remainder (a_rem)
  );

  ec_sdiv u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (b_cmd),
    .done      (b_done),
    .quotient  (b_quot),
    .remainder (b_rem)
  );

  assign leap    = year_r[1:0] == 2'b00;
  assign ylen    = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
  assign mlen    = month_days(mon_r, leap);
  assign days_in = a_quot[DAYS_W-1:0];

  always_comb begin
    a_cmd       = '0;
    b_cmd       = '0;
    state_nxt   = state_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    days_nxt    = days_r;
    year_nxt    = year_r;
    mon_nxt     = mon_r;
    wday_nxt    = wday_r;
    wday_ok_nxt = wday_ok_r;
    out_valid_nxt = 1'b0;

    if (b_done) begin
      wday_nxt    = b_rem[2:0];
      wday_ok_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_cmd.start    = 1'b1;
          a_cmd.dividend = in_epoch_seconds;
          a_cmd.nbits    = BITS_SECS;
          a_cmd.divisor  = DIV_SIXTY;
          state_nxt      = ST_SEC;
        end
      end
      ST_SEC: begin
        if (a_done) begin
          sec_nxt        = a_rem;
          a_cmd.start    = 1'b1;
          a_cmd.dividend = {a_quot[26:0], 5'b0};
          a_cmd.nbits    = BITS_MINS;
          a_cmd.divisor  = DIV_SIXTY;
          state_nxt      = ST_MIN;
        end
      end
      ST_MIN: begin
        if (a_done) begin
          min_nxt        = a_rem;
          a_cmd.start    = 1'b1;
          a_cmd.dividend = {a_quot[20:0], 11'b0};
          a_cmd.nbits    = BITS_HOURS;
          a_cmd.divisor  = DIV_DAY;
          state_nxt      = ST_HOUR;
        end
      end
      ST_HOUR: begin
        if (a_done) begin
          hour_nxt       = a_rem[4:0];
          days_nxt       = days_in;
          year_nxt       = EPOCH_YEAR;
          wday_ok_nxt    = 1'b0;
          b_cmd.start    = 1'b1;
          b_cmd.dividend = {days_in + EPOCH_WDAY, 16'b0};
          b_cmd.nbits    = BITS_DAYS;
          b_cmd.divisor  = DIV_WEEK;
          state_nxt      = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (days_r >= {7'b0, ylen}) begin
          days_nxt = days_r - {7'b0, ylen};
          year_nxt = year_r + 1'b1;
        end else begin
          mon_nxt   = '0;
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if (mon_r != LAST_MONTH && days_r >= {11'b0, mlen}) begin
          days_nxt = days_r - {11'b0, mlen};
          mon_nxt  = mon_r + 1'b1;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (wday_ok_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wday_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wday_ok_r   <= wday_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    days_r <= days_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    wday_r <= wday_nxt;
  end

  logic [5:0]  osec_r;
  logic [5:0]  omin_r;
  logic [4:0]  ohour_r;
  logic [2:0]  owday_r;
  logic [3:0]  omon_r;
  logic [4:0]  oday_r;
  logic [11:0] oyear_r;

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      osec_r  <= sec_r;
      omin_r  <= min_r;
      ohour_r <= hour_r;
      owday_r <= wday_r;
      omon_r  <= mon_r;
      oday_r  <= days_r[4:0] + 5'd1;
      oyear_r <= year_r;
    end
  end

  assign busy                 = state_r != ST_IDLE;
  assign out_valid            = out_valid_r;
  assign out_second_of_minute = osec_r;
  assign out_minute_of_hour   = omin_r;
  assign out_hour_of_day      = ohour_r;
  assign out_weekday          = owday_r;
  assign out_month_index      = omon_r;
  assign out_day_of_month     = oday_r;
  assign out_full_year        = oyear_r;

  a_result_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_WAIT)
    else $error("result strobe without a finished transaction");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MON |-> mon_r <= LAST_MONTH)
    else $error("month stepping beyond december");

  a_day_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> days_r < 16'd31)
    else $error("day within month out of range");

  a_wday_align: assert property (@(posedge clk) disable iff (!rst_n)
    b_done |-> b_quot[WORD_W-1:DAYS_W] == '0)
    else $error("weekday quotient not aligned");

endmodule
